/* rtl/btgp_pkg.sv */
`timescale 1ns / 1ps
package btgp_pkg;

  localparam int NUM_REGS = 8;
  localparam int ADDR_W = 5;
  localparam int CONF_W = 17;
  localparam int CLASS_W = 8;
  localparam int COORD_W = 32;
  localparam int USER_W = CLASS_W + 1;
  localparam int OUT_W = 152;

  typedef enum logic [2:0] {
    REG_VEHICLE_X      = 3'd0,
    REG_VEHICLE_Y      = 3'd1,
    REG_CAMERA_HEIGHT  = 3'd2,
    REG_QUAT_X         = 3'd3,
    REG_QUAT_Y         = 3'd4,
    REG_QUAT_Z         = 3'd5,
    REG_QUAT_W         = 3'd6,
    REG_CONF_THRESHOLD = 3'd7
  } reg_idx_t;

  localparam logic [24:0] CX_Q16 = 25'd18383287;
  localparam logic [24:0] CY_Q16 = 25'd15055812;
  localparam logic [23:0] INV_FX_Q32 = 24'd6845574;
  localparam logic [23:0] INV_FY_Q32 = 24'd6826475;
  localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
  localparam logic signed [33:0] CAM_FWD_Q16 = 34'sd65536;
  localparam logic [1:0] SETTLE_CYCLES = 2'd3;

  localparam int RW = 34;
  localparam int DIV_NW = 63;
  localparam int DIV_DW = 31;
  localparam int DIV_QW = 34;
  localparam int SQRT_W = 64;
  localparam int ROOT_W = 32;
  localparam int ROOT_STAGES = 32;

  typedef logic signed [RW-1:0] rot_entry_t;
  typedef rot_entry_t rot_t [9];

  typedef struct packed {
    logic [CLASS_W-1:0] cls;
    logic [CONF_W-1:0]  conf;
  } meta_t;

  typedef struct packed {
    meta_t meta;
    logic  par;
    logic  neg_x;
    logic  neg_y;
    logic  sat_x;
    logic  sat_y;
  } mid_t;

  typedef struct packed {
    meta_t                     meta;
    logic                      par;
    logic                      ovf;
    logic signed [COORD_W-1:0] gx;
    logic signed [COORD_W-1:0] gy;
  } tail_t;

  typedef struct packed {
    logic                      par;
    logic [COORD_W-1:0]        distance;
    logic signed [COORD_W-1:0] gy;
    logic signed [COORD_W-1:0] gx;
    meta_t                     meta;
  } out_item_t;

endpackage

/* rtl/box_to_ground_projection.sv */
`timescale 1ns / 1ps
// Box to ground-plane projection.
// Input channel s_*: one detection box per item. Boxes whose confidence is not
// above conf_threshold are dropped inside the pipe and give no output item.
// Output channel m_*: ground point, planar distance and the parallel-ray flag.
// Configuration: APB write/read of eight registers at byte addresses 4*i.
// Pipeline: nine arithmetic stages, a 34-stage divider, four distance stages,
// a 32-stage square root and the output register. Throughput: one box per
// cycle while s_tready is high, set by the fully pipelined divider and square
// root.
// The rotation matrix is rebuilt from the pose after reset and after every
// register write; s_tready stays low while it is rebuilt.
// When the receiver stalls, the output register holds its item and a one-item
// skid buffer catches the next; s_tready drops while the skid buffer is full and
// the whole pipe freezes, so nothing is lost or repeated.
// Reset clears all valid bits and loads the register reset values.
module box_to_ground_projection #(
  parameter int  PIXEL_BITS = 11,
  localparam int IN_W = ((4 * PIXEL_BITS + 17 + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [btgp_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // box_x_min, box_x_max, box_y_min, box_y_max, confidence, zero fill
  input  logic [IN_W-1:0]                s_tdata,
  // class_id
  input  logic [btgp_pkg::CLASS_W-1:0]   s_tuser,
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // out_confidence, ground_x, ground_y, ground_z, distance, zero fill
  output logic [btgp_pkg::OUT_W-1:0]     m_tdata,
  // out_class, ray_parallel
  output logic [btgp_pkg::USER_W-1:0]    m_tuser
);
  import btgp_pkg::*;

  localparam int AW   = PIXEL_BITS + 18;
  localparam int PW   = AW + 25;
  localparam int RAYW = PW - 27;
  localparam int MW   = RW + RAYW;
  localparam int DW   = MW + 2;
  localparam int SW   = $clog2(DW + 1);
  localparam logic signed [PW-1:0] RND27 = PW'(64'd1 << 27);

  function automatic logic [DW-1:0] mag_d(input logic signed [DW-1:0] d);
    return d[DW-1] ? DW'(-d) : DW'(d);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [35:0] s);
    logic signed [31:0] r;
    if (s > 36'sd2147483647) r = 32'sh7fff_ffff;
    else if (s < -36'sd2147483648) r = 32'sh8000_0000;
    else r = s[31:0];
    return r;
  endfunction

  // configuration registers
  logic signed [31:0] vehicle_x, vehicle_y, camera_height;
  logic signed [31:0] quat_x, quat_y, quat_z, quat_w;
  logic [CONF_W-1:0]  conf_threshold;
  logic               cfg_wr;
  logic [1:0]         settle;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      vehicle_x      <= '0;
      vehicle_y      <= '0;
      camera_height  <= '0;
      quat_x         <= '0;
      quat_y         <= '0;
      quat_z         <= '0;
      quat_w         <= ONE_Q30;
      conf_threshold <= CONF_W'(32768);
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_VEHICLE_X:      vehicle_x      <= pwdata;
        REG_VEHICLE_Y:      vehicle_y      <= pwdata;
        REG_CAMERA_HEIGHT:  camera_height  <= pwdata;
        REG_QUAT_X:         quat_x         <= pwdata;
        REG_QUAT_Y:         quat_y         <= pwdata;
        REG_QUAT_Z:         quat_z         <= pwdata;
        REG_QUAT_W:         quat_w         <= pwdata;
        REG_CONF_THRESHOLD: conf_threshold <= pwdata[CONF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_VEHICLE_X:      prdata = vehicle_x;
      REG_VEHICLE_Y:      prdata = vehicle_y;
      REG_CAMERA_HEIGHT:  prdata = camera_height;
      REG_QUAT_X:         prdata = quat_x;
      REG_QUAT_Y:         prdata = quat_y;
      REG_QUAT_Z:         prdata = quat_z;
      REG_QUAT_W:         prdata = quat_w;
      REG_CONF_THRESHOLD: prdata = 32'(conf_threshold);
      default:            prdata = '0;
    endcase
  end

  // hold input while the rotation matrix settles
  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      settle <= SETTLE_CYCLES;
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  rot_t rot;

  btgp_rot u_rot (
    .clk    (clk),
    .quat_x (quat_x),
    .quat_y (quat_y),
    .quat_z (quat_z),
    .quat_w (quat_w),
    .rot    (rot)
  );

  logic en, acc, skid_v, out_v;

  assign en       = ~skid_v;
  assign s_tready = en & (settle == 2'd0);
  assign acc      = s_tvalid & s_tready;

  // stage 1: centre pixel, offset from principal point
  logic [PIXEL_BITS-1:0] x_min, x_max, y_min, y_max;
  logic [PIXEL_BITS:0]   usum, vsum;
  logic [CONF_W-1:0]     in_conf;
  logic                  v1;
  meta_t                 meta1;
  logic signed [AW-1:0]  ay1, az1;

  assign x_min   = s_tdata[PIXEL_BITS-1:0];
  assign x_max   = s_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
  assign y_min   = s_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS];
  assign y_max   = s_tdata[4*PIXEL_BITS-1:3*PIXEL_BITS];
  assign in_conf = s_tdata[4*PIXEL_BITS+CONF_W-1:4*PIXEL_BITS];
  assign usum    = {1'b0, x_min} + {1'b0, x_max};
  assign vsum    = {1'b0, y_min} + {1'b0, y_max};

  always_ff @(posedge clk) begin
    if (en) begin
      meta1.cls  <= s_tuser;
      meta1.conf <= in_conf;
      ay1 <= $signed({2'b00, usum[PIXEL_BITS:1], 16'h0000}) - $signed(AW'(CX_Q16));
      az1 <= $signed({2'b00, vsum[PIXEL_BITS:1], 16'h0000}) - $signed(AW'(CY_Q16));
    end
  end

  // stage 2: scale by inverse focal lengths
  logic                 v2;
  meta_t                meta2;
  logic signed [PW-1:0] py2, pz2;

  always_ff @(posedge clk) begin
    if (en) begin
      meta2 <= meta1;
      py2   <= ay1 * $signed({1'b0, INV_FX_Q32});
      pz2   <= az1 * $signed({1'b0, INV_FY_Q32});
    end
  end

  // stage 3: round to Q20 ray
  logic                   v3;
  meta_t                  meta3;
  logic signed [PW-1:0]   pyr, pzr;
  logic signed [RAYW-1:0] ry3, rz3;

  assign pyr = py2 + RND27;
  assign pzr = pz2 + RND27;

  always_ff @(posedge clk) begin
    if (en) begin
      meta3 <= meta2;
      ry3   <= RAYW'($signed(pyr[PW-1:28]));
      rz3   <= -RAYW'($signed(pzr[PW-1:28]));
    end
  end

  // stage 4: matrix by ray products
  logic                 v4;
  meta_t                meta4;
  logic signed [MW-1:0] m4 [3][3];

  always_ff @(posedge clk) begin
    if (en) begin
      meta4 <= meta3;
      for (int i = 0; i < 3; i++) begin
        m4[i][0] <= MW'(rot[3*i]) <<< 20;
        m4[i][1] <= rot[3*i+1] * ry3;
        m4[i][2] <= rot[3*i+2] * rz3;
      end
    end
  end

  // stage 5: direction sums
  logic                 v5;
  meta_t                meta5;
  logic signed [DW-1:0] d5 [3];

  always_ff @(posedge clk) begin
    if (en) begin
      meta5 <= meta4;
      for (int i = 0; i < 3; i++) begin
        d5[i] <= DW'(m4[i][0]) + DW'(m4[i][1]) + DW'(m4[i][2]);
      end
    end
  end

  // stage 6: normalising shift
  logic                 v6;
  meta_t                meta6;
  logic signed [DW-1:0] d6 [3];
  logic [SW-1:0]        sh6, blen, sh_c;
  logic [DW-1:0]        magor;

  assign magor = mag_d(d5[0]) | mag_d(d5[1]) | mag_d(d5[2]);

  always_comb begin
    blen = '0;
    for (int i = 0; i < DW; i++) begin
      if (magor[i]) blen = SW'(i + 1);
    end
    sh_c = (blen > SW'(30)) ? blen - SW'(30) : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta6 <= meta5;
      d6    <= d5;
      sh6   <= sh_c;
    end
  end

  // stage 7: apply shift
  logic                 v7;
  meta_t                meta7;
  logic signed [30:0]   dn7 [3];
  logic signed [DW-1:0] dsh [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dsh[i] = d6[i] >>> sh6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta7 <= meta6;
      for (int i = 0; i < 3; i++) begin
        dn7[i] <= dsh[i][30:0];
      end
    end
  end

  // stage 8: height by direction
  logic               v8;
  meta_t              meta8;
  logic signed [62:0] prx8, pry8;
  logic signed [30:0] dz8;

  always_ff @(posedge clk) begin
    if (en) begin
      meta8 <= meta7;
      prx8  <= camera_height * dn7[0];
      pry8  <= camera_height * dn7[1];
      dz8   <= dn7[2];
    end
  end

  // stage 9: divider operands, rounding bias, overflow check
  logic                     v9;
  mid_t                     mid9;
  logic [DIV_NW-1:0]        num9x, num9y, numx_c, numy_c;
  logic [DIV_DW-1:0]        den9, ad_c;

  assign ad_c   = dz8[30] ? DIV_DW'(-dz8) : DIV_DW'(dz8);
  assign numx_c = (prx8[62] ? DIV_NW'(-prx8) : DIV_NW'(prx8)) + DIV_NW'(ad_c >> 1);
  assign numy_c = (pry8[62] ? DIV_NW'(-pry8) : DIV_NW'(pry8)) + DIV_NW'(ad_c >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      mid9.meta  <= meta8;
      mid9.par   <= (dz8 == '0);
      mid9.neg_x <= (prx8 > 0) ^ dz8[30];
      mid9.neg_y <= (pry8 > 0) ^ dz8[30];
      mid9.sat_x <= {2'b00, numx_c} >= {ad_c, {DIV_QW{1'b0}}};
      mid9.sat_y <= {2'b00, numy_c} >= {ad_c, {DIV_QW{1'b0}}};
      num9x <= numx_c;
      num9y <= numy_c;
      den9  <= ad_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8, v9} <= '0;
    end else if (en) begin
      v1 <= acc & (in_conf > conf_threshold);
      {v2, v3, v4, v5, v6, v7, v8, v9} <= {v1, v2, v3, v4, v5, v6, v7, v8};
    end
  end

  // divider
  logic [DIV_QW-1:0] qx, qy;
  logic [DIV_QW-1:0] vdiv;
  mid_t              mdiv [DIV_QW];

  btgp_div u_div_x (.clk(clk), .en(en), .num(num9x), .den(den9), .quo(qx));
  btgp_div u_div_y (.clk(clk), .en(en), .num(num9y), .den(den9), .quo(qy));

  always_ff @(posedge clk) begin
    if (rst) begin
      vdiv <= '0;
    end else if (en) begin
      vdiv <= {vdiv[DIV_QW-2:0], v9};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mdiv[0] <= mid9;
      for (int k = 1; k < DIV_QW; k++) begin
        mdiv[k] <= mdiv[k-1];
      end
    end
  end

  // stage A: ground point
  mid_t               md;
  logic [DIV_QW-1:0]  qx_e, qy_e;
  logic signed [35:0] qx_s, qy_s, sumx, sumy;
  logic signed [33:0] basex, basey;
  logic               va, vb, vc, vd;
  tail_t              ta, tb, tc, td;

  assign md    = mdiv[DIV_QW-1];
  assign qx_e  = md.sat_x ? '1 : qx;
  assign qy_e  = md.sat_y ? '1 : qy;
  assign qx_s  = md.neg_x ? -$signed({2'b00, qx_e}) : $signed({2'b00, qx_e});
  assign qy_s  = md.neg_y ? -$signed({2'b00, qy_e}) : $signed({2'b00, qy_e});
  assign basex = 34'(vehicle_x) + CAM_FWD_Q16;
  assign basey = 34'(vehicle_y);
  assign sumx  = 36'(basex) + qx_s;
  assign sumy  = 36'(basey) + qy_s;

  always_ff @(posedge clk) begin
    if (en) begin
      ta.meta <= md.meta;
      ta.par  <= md.par;
      ta.ovf  <= 1'b0;
      ta.gx   <= md.par ? '0 : sat32(sumx);
      ta.gy   <= md.par ? '0 : sat32(sumy);
    end
  end

  // stage B: offsets from vehicle
  logic signed [32:0] ddx, ddy;
  logic [31:0]        exb, eyb;

  assign ddx = 33'(ta.gx) - 33'(vehicle_x);
  assign ddy = 33'(ta.gy) - 33'(vehicle_y);

  always_ff @(posedge clk) begin
    if (en) begin
      tb  <= ta;
      exb <= ddx[32] ? 32'(-ddx) : ddx[31:0];
      eyb <= ddy[32] ? 32'(-ddy) : ddy[31:0];
    end
  end

  // stage C: squares
  logic [63:0] sxc, syc;

  always_ff @(posedge clk) begin
    if (en) begin
      tc  <= tb;
      sxc <= exb * exb;
      syc <= eyb * eyb;
    end
  end

  // stage D: sum with overflow
  logic [64:0]       ssum;
  logic [SQRT_W-1:0] xd;

  assign ssum = {1'b0, sxc} + {1'b0, syc};

  always_ff @(posedge clk) begin
    if (en) begin
      td <= '{meta: tc.meta, par: tc.par, ovf: ssum[64], gx: tc.gx, gy: tc.gy};
      xd <= ssum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      {va, vb, vc, vd} <= '0;
    end else if (en) begin
      {va, vb, vc, vd} <= {vdiv[DIV_QW-1], va, vb, vc};
    end
  end

  // square root
  logic [ROOT_W-1:0]      root;
  logic [ROOT_STAGES-1:0] vsq;
  tail_t                  tsq [ROOT_STAGES];

  btgp_isqrt u_isqrt (.clk(clk), .en(en), .x(xd), .root(root));

  always_ff @(posedge clk) begin
    if (rst) begin
      vsq <= '0;
    end else if (en) begin
      vsq <= {vsq[ROOT_STAGES-2:0], vd};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tsq[0] <= td;
      for (int k = 1; k < ROOT_STAGES; k++) begin
        tsq[k] <= tsq[k-1];
      end
    end
  end

  // output register and skid buffer
  tail_t     tl;
  out_item_t pipe_item, out_item, skid_item;
  logic      pipe_v, take_out;

  assign tl     = tsq[ROOT_STAGES-1];
  assign pipe_v = vsq[ROOT_STAGES-1];

  always_comb begin
    pipe_item.meta = tl.meta;
    pipe_item.par  = tl.par;
    pipe_item.gx   = tl.gx;
    pipe_item.gy   = tl.gy;
    if (tl.par) pipe_item.distance = '0;
    else if (tl.ovf) pipe_item.distance = '1;
    else pipe_item.distance = root;
  end

  assign take_out = ~out_v | m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v  <= 1'b0;
      skid_v <= 1'b0;
    end else if (take_out) begin
      out_v  <= skid_v | pipe_v;
      skid_v <= 1'b0;
    end else if (pipe_v && !skid_v) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_out) begin
      out_item <= skid_v ? skid_item : pipe_item;
    end else if (pipe_v && !skid_v) begin
      skid_item <= pipe_item;
    end
  end

  assign m_tvalid = out_v;
  assign m_tdata  = {7'b0, out_item.distance, 32'b0, out_item.gy, out_item.gx,
                     out_item.meta.conf};
  assign m_tuser  = {out_item.par, out_item.meta.cls};

`ifndef SYNTHESIS
  a_skid_has_out: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> out_v) else $error("skid item without output item");

  a_skid_blocks_in: assert property (@(posedge clk) disable iff (rst)
    skid_v |-> !s_tready) else $error("input taken while skid buffer full");

  a_cfg_blocks_in: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> !s_tready) else $error("input taken during matrix refresh");

  a_parallel_zero: assert property (@(posedge clk) disable iff (rst)
    out_v && out_item.par |-> out_item.distance == '0 && out_item.gx == '0 &&
    out_item.gy == '0) else $error("parallel ray with nonzero result");
`endif

endmodule

/* rtl/btgp_rot.sv */
`timescale 1ns / 1ps
module btgp_rot (
  input  logic               clk,
  input  logic signed [31:0] quat_x,
  input  logic signed [31:0] quat_y,
  input  logic signed [31:0] quat_z,
  input  logic signed [31:0] quat_w,
  output btgp_pkg::rot_t     rot
);
  import btgp_pkg::*;

  function automatic logic signed [31:0] clamp_q(input logic signed [31:0] q);
    logic signed [31:0] r;
    r = q;
    if (q > ONE_Q30) r = ONE_Q30;
    if (q < -ONE_Q30) r = -ONE_Q30;
    return r;
  endfunction

  function automatic rot_entry_t rnd30(input logic signed [63:0] s);
    logic signed [63:0] t;
    t = s + 64'sd536870912;
    return t[63:30];
  endfunction

  logic signed [31:0] qx, qy, qz, qw;
  logic signed [63:0] pww, pxx, pyy, pzz, pxy, pwz, pwy, pxz, pyz, pwx;

  assign qx = clamp_q(quat_x);
  assign qy = clamp_q(quat_y);
  assign qz = clamp_q(quat_z);
  assign qw = clamp_q(quat_w);

  always_ff @(posedge clk) begin
    pww <= qw * qw;
    pxx <= qx * qx;
    pyy <= qy * qy;
    pzz <= qz * qz;
    pxy <= qx * qy;
    pwz <= qw * qz;
    pwy <= qw * qy;
    pxz <= qx * qz;
    pyz <= qy * qz;
    pwx <= qw * qx;
  end

  always_ff @(posedge clk) begin
    rot[0] <= rnd30(pww + pxx - pyy - pzz);
    rot[1] <= rnd30((pxy - pwz) <<< 1);
    rot[2] <= rnd30((pwy + pxz) <<< 1);
    rot[3] <= rnd30((pwz + pxy) <<< 1);
    rot[4] <= rnd30(pww - pxx + pyy - pzz);
    rot[5] <= rnd30((pyz - pwx) <<< 1);
    rot[6] <= rnd30((pxz - pwy) <<< 1);
    rot[7] <= rnd30((pwx + pyz) <<< 1);
    rot[8] <= rnd30(pww - pxx - pyy + pzz);
  end

endmodule

/* rtl/btgp_div.sv */
`timescale 1ns / 1ps
module btgp_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [btgp_pkg::DIV_NW-1:0] num,
  input  logic [btgp_pkg::DIV_DW-1:0] den,
  output logic [btgp_pkg::DIV_QW-1:0] quo
);
  import btgp_pkg::*;

  logic [DIV_DW-1:0] rem_r [DIV_QW];
  logic [DIV_DW-1:0] den_r [DIV_QW];
  logic [DIV_QW-1:0] lo_r  [DIV_QW];
  logic [DIV_QW-1:0] q_r   [DIV_QW];

  for (genvar k = 0; k < DIV_QW; k++) begin : g_stage
    logic [DIV_DW-1:0] rem_c, den_c;
    logic [DIV_QW-1:0] lo_c, q_c;
    logic [DIV_DW:0]   t;
    logic              take;

    if (k == 0) begin : g_first
      assign rem_c = DIV_DW'(num[DIV_NW-1:DIV_QW]);
      assign den_c = den;
      assign lo_c  = num[DIV_QW-1:0];
      assign q_c   = '0;
    end else begin : g_next
      assign rem_c = rem_r[k-1];
      assign den_c = den_r[k-1];
      assign lo_c  = lo_r[k-1];
      assign q_c   = q_r[k-1];
    end

    assign t    = {rem_c, lo_c[DIV_QW-1]};
    assign take = t >= {1'b0, den_c};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? DIV_DW'(t - {1'b0, den_c}) : t[DIV_DW-1:0];
        den_r[k] <= den_c;
        lo_r[k]  <= lo_c << 1;
        q_r[k]   <= {q_c[DIV_QW-2:0], take};
      end
    end
  end

  assign quo = q_r[DIV_QW-1];

endmodule

/* rtl/btgp_isqrt.sv */
`timescale 1ns / 1ps
module btgp_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [btgp_pkg::SQRT_W-1:0] x,
  output logic [btgp_pkg::ROOT_W-1:0] root
);
  import btgp_pkg::*;

  logic [SQRT_W-1:0] x_r   [ROOT_STAGES];
  logic [SQRT_W-1:0] res_r [ROOT_STAGES];

  for (genvar k = 0; k < ROOT_STAGES; k++) begin : g_stage
    localparam logic [SQRT_W-1:0] B = SQRT_W'(1) << (SQRT_W - 2 - 2 * k);
    logic [SQRT_W-1:0] x_c, res_c, trial;
    logic              take;

    if (k == 0) begin : g_first
      assign x_c   = x;
      assign res_c = '0;
    end else begin : g_next
      assign x_c   = x_r[k-1];
      assign res_c = res_r[k-1];
    end

    assign trial = res_c + B;
    assign take  = x_c >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]   <= take ? x_c - trial : x_c;
        res_r[k] <= take ? (res_c >> 1) + B : res_c >> 1;
      end
    end
  end

  assign root = res_r[ROOT_STAGES-1][ROOT_W-1:0];

endmodule
